// ----- rtl/core/sfp_pkg.sv -----
// sfp_pkg: shared constants and types for the sensor frame parser.
// No dependencies; used by sensor_frame_parser_core, sfp_parser and sfp_out_reg.
`default_nettype none

package sfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] FRAME_TYPE = 8'h01;
  localparam logic [7:0] FRAME_LEN  = 8'h04;

  localparam int PAYLOAD_BYTES = 4;

  // parser phase codes
  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  // body byte positions
  localparam logic [2:0] POS_TYPE  = 3'd0;
  localparam logic [2:0] POS_LEN   = 3'd1;
  localparam logic [2:0] POS_DATA0 = 3'd2;
  localparam logic [2:0] POS_DATA1 = 3'd3;
  localparam logic [2:0] POS_DATA2 = 3'd4;
  localparam logic [2:0] POS_DATA3 = 3'd5;

  typedef struct packed {
    logic [15:0] temperature_tenths;
    logic [15:0] humidity_tenths;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/sensor_frame_parser_core.sv -----
// sensor_frame_parser_core: top level of the byte-serial sensor frame parser.
// Depends on sfp_pkg, sfp_in_reg, sfp_parser and sfp_out_reg.
//
// channel | ports                                          | dir
// --------+------------------------------------------------+-----
// input   | in_valid, in_stall, in_data_byte[7:0]          | in
// result  | out_valid, out_stall, out_temperature_tenths,  | out
//         | out_humidity_tenths                            |
//
// One byte per cycle while in_stall is low: a byte is held in the input
// register, then the parser state and payload registers update; a good
// checksum byte is held in the input register and then loads the result
// register, raising out_valid, once res_ready lets the parser consume it.
// Synchronous active-low reset clears valids and parser state.
// A held result only stalls input when a second frame completes behind it.
`default_nettype none

module sensor_frame_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_temperature_tenths,
  output logic [15:0]      out_humidity_tenths
);

  logic             consume;
  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             res_valid;
  logic             res_ready;
  sfp_pkg::result_t res;

  sfp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .consume      (consume),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data)
  );

  sfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .res_ready  (res_ready),
    .consume    (consume),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfp_out_reg u_out_reg (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .res_valid              (res_valid),
    .res                    (res),
    .res_ready              (res_ready),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_temperature_tenths (out_temperature_tenths),
    .out_humidity_tenths    (out_humidity_tenths)
  );

endmodule

`default_nettype wire

// ----- rtl/core/sfp_in_reg.sv -----
// sfp_in_reg: input register stage holding one received byte.
// No package dependencies; fed by the input channel.
`default_nettype none

module sfp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       consume,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       load;

  assign in_stall   = valid_r && !consume;
  assign load       = in_valid && !in_stall;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sfp_parser.sv -----
// sfp_parser: header hunt, type/length check, payload capture and checksum.
// Depends on sfp_pkg for codes and the result_t type.
`default_nettype none

module sfp_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        byte_valid,
  input  wire logic [7:0]  byte_data,
  input  wire logic        res_ready,
  output logic             consume,
  output logic             res_valid,
  output sfp_pkg::result_t res
);

  logic [1:0] phase_r, phase_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] pay_r [sfp_pkg::PAYLOAD_BYTES];
  logic       pay_we;
  logic       emit;
  logic [1:0] pay_idx;
  logic [2:0] pos_off;

  assign pos_off = pos_r - sfp_pkg::POS_DATA0;
  assign pay_idx = pos_off[1:0];

  always_comb begin
    phase_nxt = sfp_pkg::PH_HUNT1;
    pos_nxt   = sfp_pkg::POS_TYPE;
    sum_nxt   = 8'd0;
    pay_we    = 1'b0;
    emit      = 1'b0;
    unique case (phase_r)
      sfp_pkg::PH_HUNT2: begin
        if (byte_data == sfp_pkg::HDR_SECOND) begin
          phase_nxt = sfp_pkg::PH_BODY;
        end else if (byte_data == sfp_pkg::HDR_FIRST) begin
          phase_nxt = sfp_pkg::PH_HUNT2;
        end
      end
      sfp_pkg::PH_BODY: begin
        case (pos_r)
          sfp_pkg::POS_TYPE: begin
            phase_nxt = sfp_pkg::PH_BODY;
            pos_nxt   = sfp_pkg::POS_LEN;
            sum_nxt   = byte_data;
          end
          sfp_pkg::POS_LEN: begin
            if (sum_r == sfp_pkg::FRAME_TYPE && byte_data == sfp_pkg::FRAME_LEN) begin
              phase_nxt = sfp_pkg::PH_BODY;
              pos_nxt   = sfp_pkg::POS_DATA0;
              sum_nxt   = sum_r + byte_data;
            end
          end
          sfp_pkg::POS_DATA0, sfp_pkg::POS_DATA1,
          sfp_pkg::POS_DATA2, sfp_pkg::POS_DATA3: begin
            phase_nxt = sfp_pkg::PH_BODY;
            pos_nxt   = pos_r + 3'd1;
            sum_nxt   = sum_r + byte_data;
            pay_we    = 1'b1;
          end
          default: begin
            // checksum byte
            emit = (byte_data == sum_r);
          end
        endcase
      end
      default: begin
        // hunting first header byte; unused code behaves the same
        if (byte_data == sfp_pkg::HDR_FIRST) begin
          phase_nxt = sfp_pkg::PH_HUNT2;
        end
      end
    endcase
  end

  assign consume   = byte_valid && (!emit || res_ready);
  assign res_valid = consume && emit;
  assign res.temperature_tenths = {pay_r[0], pay_r[1]};
  assign res.humidity_tenths    = {pay_r[2], pay_r[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sfp_pkg::PH_HUNT1;
      pos_r   <= sfp_pkg::POS_TYPE;
      sum_r   <= 8'd0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && pay_we) begin
      pay_r[pay_idx] <= byte_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sfp_out_reg.sv -----
// sfp_out_reg: result register driving the output channel.
// Depends on sfp_pkg for the result_t type.
`default_nettype none

module sfp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire sfp_pkg::result_t  res,
  output logic                   res_ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [15:0]            out_temperature_tenths,
  output logic [15:0]            out_humidity_tenths
);

  logic             valid_r, valid_nxt;
  sfp_pkg::result_t data_r;

  assign res_ready = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_temperature_tenths = data_r.temperature_tenths;
  assign out_humidity_tenths    = data_r.humidity_tenths;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire
